FILE: src/psd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants of the port scan detector.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int SOURCES_DEF          = 256;
    localparam int PORTS_PER_SOURCE_DEF = 64;

    localparam int SRC_W   = 32;
    localparam int PORT_W  = 16;
    localparam int TIME_W  = 48;
    localparam int PKT_W   = 16;
    localparam int WIN_W   = 22;
    localparam int SPAN_W  = 23;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 16;
    localparam int SEEN_W  = 7;

    localparam logic [9:0]       MS_PER_S = 10'd1000;
    localparam logic [PKT_W-1:0] PKT_MAX  = 16'hFFFF;

    localparam logic [IDX_W-1:0] REG_WINDOW    = 2'd0;
    localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [IDX_W-1:0] REG_PROBE     = 2'd2;
    localparam logic [IDX_W-1:0] REG_AUTOBLOCK = 2'd3;

    typedef enum logic [1:0] {
        ALERT_NONE  = 2'd0,
        ALERT_SCAN  = 2'd1,
        ALERT_PROBE = 2'd2
    } t_alert;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_CHK,
        ST_ALLOC,
        ST_PSRCH,
        ST_UPD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [11:0]      window_s;
        logic [6:0]       threshold;
        logic [PKT_W-1:0] probe;
        logic             autoblock;
    } t_cfg;

    typedef struct packed {
        t_alert            alert_kind;
        logic [SEEN_W-1:0] ports_seen;
        logic              block_request;
        logic              tracked;
    } t_result;

    function automatic logic older(input logic [TIME_W-1:0] begin_ms,
                                   input logic [TIME_W-1:0] now_ms,
                                   input logic [SPAN_W-1:0] span);
        logic [TIME_W-1:0] diff;
        diff = now_ms - begin_ms;
        return (now_ms >= begin_ms) && (diff > TIME_W'(span));
    endfunction

endpackage
`default_nettype wire

FILE: src/psd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_if
// Channel interfaces of the port scan detector: probes, results, configuration.
// ----------------------------------------------------------------------------
interface psd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] src_ip;
    logic [15:0] dst_port;
    logic [47:0] now_ms;
    modport source (output valid, output src_ip, output dst_port, output now_ms,
                    input ready);
    modport sink (input valid, input src_ip, input dst_port, input now_ms,
                  output ready);
endinterface

interface psd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] alert_kind;
    logic [6:0] ports_seen;
    logic       block_request;
    logic       tracked;
    modport source (output valid, output alert_kind, output ports_seen,
                    output block_request, output tracked, input ready);
    modport sink (input valid, input alert_kind, input ports_seen,
                  input block_request, input tracked, output ready);
endinterface

interface psd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: src/psd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module psd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [WIDTH-1:0]           i_wdata,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: src/psd_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_engine
// Sequencer that searches the source table, walks the port list of the entry
// and writes the updated entry back.
// ----------------------------------------------------------------------------
module psd_engine #(
    parameter int SOURCES          = psd_pkg::SOURCES_DEF,
    parameter int PORTS_PER_SOURCE = psd_pkg::PORTS_PER_SOURCE_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    psd_in_if.sink           i_in,
    input  psd_pkg::t_cfg    i_cfg,
    output logic             o_res_valid,
    input  wire              i_res_ready,
    output psd_pkg::t_result o_res
);
    localparam int SW   = $clog2(SOURCES);
    localparam int EAW  = $clog2(SOURCES + 1);
    localparam int PCW  = $clog2(PORTS_PER_SOURCE + 1);
    localparam int PAW  = $clog2(SOURCES * PORTS_PER_SOURCE);
    localparam int CW   = (PCW > 7) ? PCW : 7;
    localparam int EW   = psd_pkg::SRC_W + psd_pkg::TIME_W + psd_pkg::PKT_W + PCW + 1;
    localparam int O_REP  = 0;
    localparam int O_PCNT = 1;
    localparam int O_PKT  = O_PCNT + PCW;
    localparam int O_BEG  = O_PKT + psd_pkg::PKT_W;
    localparam int O_SRC  = O_BEG + psd_pkg::TIME_W;

    psd_pkg::t_state r_state, n_state;
    logic [31:0]  r_src, n_src;
    logic [15:0]  r_port, n_port;
    logic [47:0]  r_now, n_now;
    logic [psd_pkg::WIN_W-1:0] r_win, n_win;
    logic [EAW-1:0] r_fill, n_fill;
    logic [EAW-1:0] r_ea, n_ea;
    logic           r_erv, n_erv;
    logic [SW-1:0]  r_eri, n_eri;
    logic           r_old_found, n_old_found;
    logic [SW-1:0]  r_old_idx, n_old_idx;
    logic [SW-1:0]  r_eidx, n_eidx;
    logic [47:0]    r_begin, n_begin;
    logic [15:0]    r_pkt, n_pkt;
    logic [PCW-1:0] r_pcnt, n_pcnt;
    logic           r_rep, n_rep;
    logic [PAW-1:0] r_base, n_base;
    logic [PCW-1:0] r_pa, n_pa;
    logic           r_prv, n_prv;
    logic           r_found, n_found;
    psd_pkg::t_result r_res, n_res;

    logic [EW-1:0]  ent_rdata, ent_wdata;
    logic           ent_we;
    logic [15:0]    port_rdata;
    logic           port_we;
    logic [PAW-1:0] port_raddr, port_waddr;
    logic [psd_pkg::SPAN_W-1:0] win1, win2;
    logic [PCW-1:0] new_cnt;
    logic [15:0]    new_pkt;
    logic           is_scan, scan_now;

    assign win1 = psd_pkg::SPAN_W'(r_win);
    assign win2 = {r_win, 1'b0};
    assign port_raddr = r_base + PAW'(r_pa);
    assign port_waddr = r_base + PAW'(r_pcnt);

    psd_ram #(.WIDTH(EW), .DEPTH(SOURCES)) u_ent_ram (
        .i_clk  (i_clk),
        .i_we   (ent_we),
        .i_waddr(r_eidx),
        .i_wdata(ent_wdata),
        .i_raddr(r_ea[SW-1:0]),
        .o_rdata(ent_rdata)
    );

    psd_ram #(.WIDTH(16), .DEPTH(SOURCES * PORTS_PER_SOURCE)) u_port_ram (
        .i_clk  (i_clk),
        .i_we   (port_we),
        .i_waddr(port_waddr),
        .i_wdata(r_port),
        .i_raddr(port_raddr),
        .o_rdata(port_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psd_pkg::ST_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
        r_src       <= n_src;
        r_port      <= n_port;
        r_now       <= n_now;
        r_win       <= n_win;
        r_ea        <= n_ea;
        r_erv       <= n_erv;
        r_eri       <= n_eri;
        r_old_found <= n_old_found;
        r_old_idx   <= n_old_idx;
        r_eidx      <= n_eidx;
        r_begin     <= n_begin;
        r_pkt       <= n_pkt;
        r_pcnt      <= n_pcnt;
        r_rep       <= n_rep;
        r_base      <= n_base;
        r_pa        <= n_pa;
        r_prv       <= n_prv;
        r_found     <= n_found;
        r_res       <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_src       = r_src;
        n_port      = r_port;
        n_now       = r_now;
        n_win       = r_win;
        n_fill      = r_fill;
        n_ea        = r_ea;
        n_erv       = 1'b0;
        n_eri       = r_eri;
        n_old_found = r_old_found;
        n_old_idx   = r_old_idx;
        n_eidx      = r_eidx;
        n_begin     = r_begin;
        n_pkt       = r_pkt;
        n_pcnt      = r_pcnt;
        n_rep       = r_rep;
        n_base      = r_base;
        n_pa        = r_pa;
        n_prv       = 1'b0;
        n_found     = r_found;
        n_res       = r_res;
        ent_we      = 1'b0;
        port_we     = 1'b0;
        i_in.ready  = 1'b0;
        o_res_valid = 1'b0;

        new_cnt  = (!r_found && r_pcnt != PCW'(PORTS_PER_SOURCE)) ? r_pcnt + 1'b1 : r_pcnt;
        new_pkt  = (r_pkt == psd_pkg::PKT_MAX) ? r_pkt : r_pkt + 1'b1;
        is_scan  = CW'(new_cnt) >= CW'(i_cfg.threshold);
        scan_now = is_scan && !r_rep;
        ent_wdata = {r_src, r_begin, new_pkt, new_cnt, r_rep | scan_now};

        case (r_state)
            psd_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_src       = i_in.src_ip;
                    n_port      = i_in.dst_port;
                    n_now       = i_in.now_ms;
                    n_win       = psd_pkg::WIN_W'(i_cfg.window_s) *
                                  psd_pkg::WIN_W'(psd_pkg::MS_PER_S);
                    n_ea        = '0;
                    n_old_found = 1'b0;
                    n_state     = psd_pkg::ST_SRCH;
                end
            end
            psd_pkg::ST_SRCH: begin
                if (r_ea != r_fill) begin
                    n_ea  = r_ea + 1'b1;
                    n_erv = 1'b1;
                    n_eri = r_ea[SW-1:0];
                end
                if (r_erv && !r_old_found &&
                    psd_pkg::older(ent_rdata[O_BEG +: 48], r_now, win2)) begin
                    n_old_found = 1'b1;
                    n_old_idx   = r_eri;
                end
                if (r_erv && ent_rdata[O_SRC +: 32] == r_src) begin
                    n_eidx  = r_eri;
                    n_begin = ent_rdata[O_BEG +: 48];
                    n_pkt   = ent_rdata[O_PKT +: 16];
                    n_pcnt  = ent_rdata[O_PCNT +: PCW];
                    n_rep   = ent_rdata[O_REP];
                    n_erv   = 1'b0;
                    n_state = psd_pkg::ST_CHK;
                end else if (!r_erv && r_ea == r_fill) begin
                    n_state = psd_pkg::ST_ALLOC;
                end
            end
            psd_pkg::ST_CHK: begin
                if (psd_pkg::older(r_begin, r_now, win1)) begin
                    n_begin = r_now;
                    n_pkt   = '0;
                    n_pcnt  = '0;
                    n_rep   = 1'b0;
                end
                n_base  = PAW'(r_eidx) * PAW'(PORTS_PER_SOURCE);
                n_pa    = '0;
                n_state = psd_pkg::ST_PSRCH;
            end
            psd_pkg::ST_ALLOC: begin
                n_begin = r_now;
                n_pkt   = '0;
                n_pcnt  = '0;
                n_rep   = 1'b0;
                n_pa    = '0;
                n_state = psd_pkg::ST_PSRCH;
                if (r_fill != EAW'(SOURCES)) begin
                    n_eidx = r_fill[SW-1:0];
                    n_fill = r_fill + 1'b1;
                end else if (r_old_found) begin
                    n_eidx = r_old_idx;
                end else begin
                    n_res.alert_kind    = psd_pkg::ALERT_NONE;
                    n_res.ports_seen    = '0;
                    n_res.block_request = 1'b0;
                    n_res.tracked       = 1'b0;
                    n_state             = psd_pkg::ST_OUT;
                end
                n_base = PAW'(n_eidx) * PAW'(PORTS_PER_SOURCE);
            end
            psd_pkg::ST_PSRCH: begin
                if (r_pa != r_pcnt) begin
                    n_pa  = r_pa + 1'b1;
                    n_prv = 1'b1;
                end
                if (r_prv && port_rdata == r_port) begin
                    n_found = 1'b1;
                    n_state = psd_pkg::ST_UPD;
                end else if (!r_prv && r_pa == r_pcnt) begin
                    n_found = 1'b0;
                    n_state = psd_pkg::ST_UPD;
                end
            end
            psd_pkg::ST_UPD: begin
                ent_we  = 1'b1;
                port_we = !r_found && r_pcnt != PCW'(PORTS_PER_SOURCE);
                n_res.ports_seen    = psd_pkg::SEEN_W'(new_cnt);
                n_res.tracked       = 1'b1;
                n_res.block_request = scan_now & i_cfg.autoblock;
                if (scan_now) begin
                    n_res.alert_kind = psd_pkg::ALERT_SCAN;
                end else if (!is_scan && new_pkt == i_cfg.probe) begin
                    n_res.alert_kind = psd_pkg::ALERT_PROBE;
                end else begin
                    n_res.alert_kind = psd_pkg::ALERT_NONE;
                end
                n_state = psd_pkg::ST_OUT;
            end
            psd_pkg::ST_OUT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = psd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = psd_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

FILE: src/port_scan_detector_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// port_scan_detector_core
// Per-source port scan detector over a time window, one result per probe.
// ----------------------------------------------------------------------------
// The work on one probe, from its acceptance to the acceptance of the next
// one, grows with N and K. N is the number of source table entries in use
// (at most SOURCES), read one per cycle from the entry RAM, and K is the number
// of ports already stored for the source, read one per cycle from the port
// RAM. A finished result waits in an output register, so the next probe is
// accepted while it is still pending. Configuration writes are accepted every
// cycle and must be made while no probe is in work.
module port_scan_detector_core #(
    parameter int SOURCES          = psd_pkg::SOURCES_DEF,
    parameter int PORTS_PER_SOURCE = psd_pkg::PORTS_PER_SOURCE_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    psd_in_if.sink     i_in,
    psd_out_if.source  o_out,
    psd_cfg_if.sink    i_cfg
);
    psd_pkg::t_cfg    r_cfg;
    psd_pkg::t_result res, r_out;
    logic             res_valid, res_ready, r_ovalid;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_s  <= 12'd60;
            r_cfg.threshold <= 7'd10;
            r_cfg.probe     <= 16'd1;
            r_cfg.autoblock <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                psd_pkg::REG_WINDOW:    r_cfg.window_s  <= i_cfg.data[11:0];
                psd_pkg::REG_THRESHOLD: r_cfg.threshold <= i_cfg.data[6:0];
                psd_pkg::REG_PROBE:     r_cfg.probe     <= i_cfg.data;
                psd_pkg::REG_AUTOBLOCK: r_cfg.autoblock <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    psd_engine #(
        .SOURCES         (SOURCES),
        .PORTS_PER_SOURCE(PORTS_PER_SOURCE)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg      (r_cfg),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res      (res)
    );

    assign res_ready = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.alert_kind    = r_out.alert_kind;
    assign o_out.ports_seen    = r_out.ports_seen;
    assign o_out.block_request = r_out.block_request;
    assign o_out.tracked       = r_out.tracked;
endmodule
`default_nettype wire
